// ----- rtl/lorenz_rk4_integrator_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef LORENZ_RK4_INTEGRATOR_TOP_ASSERT_SVH
`define LORENZ_RK4_INTEGRATOR_TOP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LRK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define LRK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lrk_pkg.sv -----
`default_nettype none
package lrk_pkg;
  localparam int unsigned STATE_DIMS = 3;
  localparam int unsigned CoefW = 24;
  localparam int unsigned DtW = 17;
  localparam int unsigned CfgW = 24;
  localparam int unsigned IdxW = 2;

  localparam logic [IdxW-1:0] REG_SIGMA = 2'd0;
  localparam logic [IdxW-1:0] REG_RHO   = 2'd1;
  localparam logic [IdxW-1:0] REG_BETA  = 2'd2;
  localparam logic [IdxW-1:0] REG_DT    = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] load_x;
    logic [31:0] load_y;
    logic [31:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic [31:0] z_out;
  } out_item_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) r = 32'sh7fffffff;
    else if (v < -72'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/lrk_stream_if.sv -----
`default_nettype none
interface lrk_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/lorenz_rk4_integrator_top.sv -----
// Channel | Dir | Payload
// in_ch   | in  | action, load_x, load_y, load_z
// out_ch  | out | x_out, y_out, z_out
// Load item: the coordinates are loaded, then S_OUT raises result valid.
// Step item: 28 multiplier slots (7 per stage for three stages, then 4 derivative
// and 3 update slots), each S_MUL then S_ACC; S_DIV divides by six in update slots.
// One shared 36x33 multiplier serves all slots; one step runs at a time.
// rst is synchronous; it clears state, coordinates and registers to reset.
// in ready only while idle; a stalled result holds in the output register.
`default_nettype none
module lorenz_rk4_integrator_top (
  input  wire logic clk,
  input  wire logic rst,
  lrk_stream_if.sink   in_ch,
  lrk_stream_if.source out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [lrk_pkg::IdxW-1:0] cfg_index,
  input  wire logic [lrk_pkg::CfgW-1:0] cfg_data
);
  import lrk_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_ACC, S_OUT} state_t;

  state_t state;
  logic [CoefW-1:0] sigma, rho, beta;
  logic [DtW-1:0] step_size;
  logic signed [31:0] cx, cy, cz;
  logic signed [31:0] pt [STATE_DIMS];
  logic signed [31:0] kk [STATE_DIMS];
  logic signed [35:0] ks [STATE_DIMS];
  logic [1:0] stage;
  logic [3:0] slot;
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic [4:0] sh;
  logic signed [73:0] prod;
  logic signed [71:0] rq;
  logic signed [31:0] t0, t1;
  out_item_t res;

  // Multiplier operand selection per slot.
  always_comb begin
    ma = '0; mb = '0; sh = 5'd16;
    unique case (slot)
      4'd0: begin ma = 36'(sat32(72'(pt[1]) - 72'(pt[0])));
        mb = 33'($signed({1'b0, sigma})); end
      4'd1: begin ma = 36'(pt[0]);
        mb = 33'(sat32(72'($signed({1'b0, rho})) - 72'(pt[2]))); end
      4'd2: begin ma = 36'(pt[0]); mb = 33'(pt[1]); end
      4'd3: begin ma = 36'(pt[2]); mb = 33'($signed({1'b0, beta})); end
      4'd4, 4'd5, 4'd6: begin
        ma = 36'(kk[2'(slot - 4'd4)]);
        mb = 33'($signed({1'b0, step_size}));
        sh = (stage == 2'd2) ? 5'd16 : 5'd17;
      end
      4'd7, 4'd8, 4'd9: begin
        ma = 36'(ks[2'(slot - 4'd7)]);
        mb = 33'($signed({1'b0, step_size}));
        sh = 5'd16;
      end
      default: ;
    endcase
  end

  // Rounded product, ties away from zero; update slots divide by 6 * 2^16.
  // The update quotient splits a = hi * 2^18 + lo, and since 2^18 = 3 * 87381 + 1,
  // a / 3 = hi * 87381 + (hi + lo) / 3, the last by reciprocal multiplication.
  logic [73:0] pmag;
  logic [73:0] qmag;
  logic [34:0] ua;
  logic [18:0] us;
  logic [39:0] us_prod;
  logic [34:0] uq, uq_next;
  always_comb begin
    pmag = prod[73] ? 74'(-prod) : 74'(prod);
    qmag = (pmag + (74'd1 << (sh - 5'd1))) >> sh;
    ua = 35'((pmag + 74'd196608) >> 17);
    us = 19'(ua[34:18]) + 19'(ua[17:0]);
    us_prod = 40'(us) * 40'd699051;
    uq_next = 35'(ua[34:18]) * 35'd87381 + 35'(us_prod[39:21]);
    if (slot >= 4'd7) rq = prod[73] ? -72'(uq) : 72'(uq);
    else rq = prod[73] ? -72'(qmag) : 72'(qmag);
  end

  // Sequencer, registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sigma <= CoefW'(786432); rho <= CoefW'(786432);
      beta <= CoefW'(393216); step_size <= DtW'(655);
      cx <= '0; cy <= '0; cz <= '0;
      slot <= '0; stage <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIGMA: sigma <= cfg_data;
          REG_RHO:   rho <= cfg_data;
          REG_BETA:  beta <= cfg_data;
          REG_DT:    step_size <= cfg_data[DtW-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && !out_ch.valid) begin
          if (in_ch.data.action == ACT_LOAD) begin
            cx <= in_ch.data.load_x; cy <= in_ch.data.load_y;
            cz <= in_ch.data.load_z;
            state <= S_OUT;
          end else begin
            pt[0] <= cx; pt[1] <= cy; pt[2] <= cz;
            ks[0] <= '0; ks[1] <= '0; ks[2] <= '0;
            stage <= '0; slot <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= 74'(ma * mb);
          state <= (slot >= 4'd7) ? S_DIV : S_ACC;
        end
        S_DIV: begin
          uq <= uq_next;
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_MUL;
          slot <= slot + 4'd1;
          unique case (slot)
            4'd0: kk[0] <= sat32(rq);
            4'd1: t0 <= sat32(rq);
            4'd2: begin t1 <= sat32(rq);
              kk[1] <= sat32(72'(t0) - 72'(pt[1])); end
            4'd3: begin
              kk[2] <= sat32(72'(t1) - 72'(sat32(rq)));
              ks[0] <= ks[0] + ((stage == 2'd0 || stage == 2'd3) ?
                36'(kk[0]) : 36'(kk[0]) <<< 1);
              ks[1] <= ks[1] + ((stage == 2'd0 || stage == 2'd3) ?
                36'(kk[1]) : 36'(kk[1]) <<< 1);
              ks[2] <= ks[2] + ((stage == 2'd0 || stage == 2'd3) ?
                36'(sat32(72'(t1) - 72'(sat32(rq)))) :
                36'(sat32(72'(t1) - 72'(sat32(rq)))) <<< 1);
              if (stage == 2'd3) slot <= 4'd7;
            end
            4'd4: pt[0] <= sat32(72'(cx) + 72'(sat32(rq)));
            4'd5: pt[1] <= sat32(72'(cy) + 72'(sat32(rq)));
            4'd6: begin pt[2] <= sat32(72'(cz) + 72'(sat32(rq)));
              slot <= '0; stage <= stage + 2'd1; end
            4'd7: cx <= sat32(72'(cx) + rq);
            4'd8: cy <= sat32(72'(cy) + rq);
            4'd9: begin cz <= sat32(72'(cz) + rq); state <= S_OUT; end
            default: ;
          endcase
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res = '{x_out: cx, y_out: cy, z_out: cz};
  assign out_ch.data = res;
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
endmodule
`default_nettype wire

// ----- rtl/lrk_checker.sv -----
`default_nettype none
`include "lorenz_rk4_integrator_top_assert.svh"
module lrk_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [95:0] out_data
);
  // One item at a time: no accept while a result waits.
  `LRK_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "ready with result pending")
  // Accept drops ready.
  `LRK_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  // Held result stays put.
  `LRK_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data),
    "result changed under stall")
endmodule
bind lorenz_rk4_integrator_top lrk_checker u_chk (.clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
